// ===== hw/rtl/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants of the text console cursor controller.
// ----------------------------------------------------------------------------
package tcc_pkg;

   localparam int MAX_COLS_DEF     = 256;
   localparam int MAX_ROWS_DEF     = 128;
   localparam int GLYPH_HEIGHT_DEF = 16;
   localparam int QUEUE_DEPTH_DEF  = 4;

   // widest command burst caused by one request
   localparam int SLOTS = 3;

   localparam logic [8:0]  COLUMNS_RESET = 9'd80;
   localparam logic [7:0]  ROWS_RESET    = 8'd25;
   localparam logic [11:0] HEIGHT_RESET  = 12'd400;
   localparam logic [3:0]  FG_RESET      = 4'd7;
   localparam logic [3:0]  BG_RESET      = 4'd0;

   localparam logic [6:0] CH_BS       = 7'd8;
   localparam logic [6:0] CH_TAB      = 7'd9;
   localparam logic [6:0] CH_LF       = 7'd10;
   localparam logic [6:0] CH_CR       = 7'd13;
   localparam logic [6:0] CH_QUESTION = 7'h3F;
   localparam int         TAB_STOP    = 8;

   typedef enum logic [1:0] {
      CSR_COLUMNS = 2'd0,
      CSR_ROWS    = 2'd1,
      CSR_HEIGHT  = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_PUT_CHAR    = 3'd0,
      OP_SET_CURSOR  = 3'd1,
      OP_CLEAR       = 3'd2,
      OP_SCROLL      = 3'd3,
      OP_SET_COLOR   = 3'd4,
      OP_RESET_COLOR = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      CMD_DRAW         = 2'd0,
      CMD_CLEAR_CELL   = 2'd1,
      CMD_SCROLL_UP    = 2'd2,
      CMD_CLEAR_SCREEN = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] char_code;
      logic [6:0] target_row;
      logic [7:0] target_col;
      logic [7:0] line_count;
      logic [7:0] color_attr;
   } req_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [6:0] glyph_code;
      logic [6:0] cell_row;
      logic [7:0] cell_col;
      logic [3:0] fg_index;
      logic [3:0] bg_index;
      logic [7:0] scroll_lines;
      logic       last;
   } rsp_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [6:0] glyph;
      logic [6:0] row;
      logic [7:0] col;
      logic [7:0] lines;
   } slot_type;

   // one classified request: its commands in order, their count and colours
   typedef struct packed {
      slot_type [SLOTS-1:0] slot;
      logic [1:0]           count;
      logic [3:0]           fg;
      logic [3:0]           bg;
   } job_type;

endpackage

// ===== hw/rtl/tcc_front.sv =====
// ----------------------------------------------------------------------------
// tcc_front
// Accepts requests, tracks cursor and colours, and turns each request into
// a job of up to three renderer commands.
// ----------------------------------------------------------------------------
module tcc_front
   import tcc_pkg::*;
#(
   parameter int MAX_COLS     = MAX_COLS_DEF,
   parameter int MAX_ROWS     = MAX_ROWS_DEF,
   parameter int GLYPH_HEIGHT = GLYPH_HEIGHT_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   output logic          full,
   input  req_type       req_data,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [11:0]   csr_wdata,
   input  logic          q_full,
   output logic          q_push,
   output job_type       q_job
);

   localparam int COL_CAP = (MAX_COLS < 256) ? MAX_COLS : 256;
   localparam int ROW_CAP = (MAX_ROWS < 128) ? MAX_ROWS : 128;
   localparam int PX_W    = 8 + $clog2(GLYPH_HEIGHT + 1);

   typedef struct packed {
      logic [6:0] row;
      logic       scrolled;
   } nl_type;

   logic [8:0]  columns_ff, columns_in;
   logic [7:0]  rows_ff, rows_in;
   logic [11:0] height_ff, height_in;
   logic [7:0]  col_ff, col_in;
   logic [6:0]  row_ff, row_in;
   logic [3:0]  fg_ff, fg_in;
   logic [3:0]  bg_ff, bg_in;

   logic [8:0]    cols_eff;
   logic [7:0]    rows_eff;
   logic          glyph_tall;
   logic [PX_W-1:0] scroll_px;
   logic          accept;
   job_type       job;

   always_comb begin
      if (columns_ff == 9'd0) begin
         cols_eff = 9'd1;
      end else if (columns_ff > 9'(COL_CAP)) begin
         cols_eff = 9'(COL_CAP);
      end else begin
         cols_eff = columns_ff;
      end
      if (rows_ff == 8'd0) begin
         rows_eff = 8'd1;
      end else if (rows_ff > 8'(ROW_CAP)) begin
         rows_eff = 8'(ROW_CAP);
      end else begin
         rows_eff = rows_ff;
      end
   end

   assign glyph_tall = PX_W'(GLYPH_HEIGHT) >= PX_W'(height_ff);
   assign scroll_px  = PX_W'(req_data.line_count) * PX_W'(GLYPH_HEIGHT);

   function automatic nl_type new_line(logic [6:0] row, logic [7:0] nrows);
      nl_type     r;
      logic [7:0] nxt;
      nxt = {1'b0, row} + 8'd1;
      if (nxt >= nrows) begin
         r.scrolled = 1'b1;
         r.row      = 7'(nrows - 8'd1);
      end else begin
         r.scrolled = 1'b0;
         r.row      = nxt[6:0];
      end
      return r;
   endfunction

   function automatic slot_type mk_slot(cmd_type cmd, logic [6:0] glyph, logic [6:0] row,
                                        logic [7:0] col, logic [7:0] lines);
      slot_type s;
      s.cmd   = cmd;
      s.glyph = glyph;
      s.row   = row;
      s.col   = col;
      s.lines = lines;
      return s;
   endfunction

   // scroll caused by a newline at the bottom row, or a screen clear when the glyph is at least as tall as the screen
   function automatic slot_type nl_slot(logic tall);
      if (tall) begin
         return mk_slot(CMD_CLEAR_SCREEN, 7'd0, 7'd0, 8'd0, 8'd0);
      end
      return mk_slot(CMD_SCROLL_UP, 7'd0, 7'd0, 8'd0, 8'd1);
   endfunction

   always_comb begin
      logic [8:0] col;
      logic [6:0] row;
      logic [6:0] ch;
      logic [8:0] tab_next;
      logic [1:0] cnt;
      nl_type     nl;

      col      = {1'b0, col_ff};
      row      = row_ff;
      fg_in    = fg_ff;
      bg_in    = bg_ff;
      cnt      = 2'd0;
      job.slot = '0;
      ch       = req_data.char_code[7] ? CH_QUESTION : req_data.char_code[6:0];
      tab_next = (col + 9'(TAB_STOP)) & ~9'(TAB_STOP - 1);
      nl       = '0;

      case (op_type'(req_data.op))
         OP_PUT_CHAR: begin
            case (ch)
               CH_LF: begin
                  nl  = new_line(row, rows_eff);
                  col = 9'd0;
                  row = nl.row;
                  if (nl.scrolled) begin
                     job.slot[cnt] = nl_slot(glyph_tall);
                     cnt           = cnt + 2'd1;
                  end
               end
               CH_CR: begin
                  col = 9'd0;
               end
               CH_TAB: begin
                  if (tab_next >= cols_eff) begin
                     nl  = new_line(row, rows_eff);
                     col = 9'd0;
                     row = nl.row;
                     if (nl.scrolled) begin
                        job.slot[cnt] = nl_slot(glyph_tall);
                        cnt           = cnt + 2'd1;
                     end
                  end else begin
                     col = tab_next;
                  end
               end
               CH_BS: begin
                  if (col != 9'd0) begin
                     col           = col - 9'd1;
                     job.slot[cnt] = mk_slot(CMD_CLEAR_CELL, 7'd0, row, col[7:0], 8'd0);
                     cnt           = cnt + 2'd1;
                  end
               end
               default: begin
                  // wrap first if the cursor was left at or past the right edge
                  if (col >= cols_eff) begin
                     nl  = new_line(row, rows_eff);
                     col = 9'd0;
                     row = nl.row;
                     if (nl.scrolled) begin
                        job.slot[cnt] = nl_slot(glyph_tall);
                        cnt           = cnt + 2'd1;
                     end
                  end
                  job.slot[cnt] = mk_slot(CMD_DRAW, ch, row, col[7:0], 8'd0);
                  cnt           = cnt + 2'd1;
                  col           = col + 9'd1;
                  if (col >= cols_eff) begin
                     nl  = new_line(row, rows_eff);
                     col = 9'd0;
                     row = nl.row;
                     if (nl.scrolled) begin
                        job.slot[cnt] = nl_slot(glyph_tall);
                        cnt           = cnt + 2'd1;
                     end
                  end
               end
            endcase
         end
         OP_SET_CURSOR: begin
            row = req_data.target_row;
            col = {1'b0, req_data.target_col};
         end
         OP_CLEAR: begin
            job.slot[cnt] = mk_slot(CMD_CLEAR_SCREEN, 7'd0, 7'd0, 8'd0, 8'd0);
            cnt           = cnt + 2'd1;
            col           = 9'd0;
            row           = 7'd0;
         end
         OP_SCROLL: begin
            if (scroll_px >= PX_W'(height_ff)) begin
               job.slot[cnt] = mk_slot(CMD_CLEAR_SCREEN, 7'd0, 7'd0, 8'd0, 8'd0);
               col           = 9'd0;
               row           = 7'd0;
            end else begin
               job.slot[cnt] = mk_slot(CMD_SCROLL_UP, 7'd0, 7'd0, 8'd0, req_data.line_count);
            end
            cnt = cnt + 2'd1;
         end
         OP_SET_COLOR: begin
            fg_in = req_data.color_attr[3:0];
            bg_in = req_data.color_attr[7:4];
         end
         OP_RESET_COLOR: begin
            fg_in = FG_RESET;
            bg_in = BG_RESET;
         end
         default: begin
         end
      endcase

      col_in    = col[7:0];
      row_in    = row;
      job.count = cnt;
      job.fg    = fg_in;
      job.bg    = bg_in;
   end

   always_comb begin
      columns_in = columns_ff;
      rows_in    = rows_ff;
      height_in  = height_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_COLUMNS: columns_in = csr_wdata[8:0];
            CSR_ROWS:    rows_in    = csr_wdata[7:0];
            CSR_HEIGHT:  height_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign full   = q_full;
   assign accept = push && !q_full;
   assign q_push = accept && (job.count != 2'd0);
   assign q_job  = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= COLUMNS_RESET;
         rows_ff    <= ROWS_RESET;
         height_ff  <= HEIGHT_RESET;
         col_ff     <= 8'd0;
         row_ff     <= 7'd0;
         fg_ff      <= FG_RESET;
         bg_ff      <= BG_RESET;
      end else begin
         columns_ff <= columns_in;
         rows_ff    <= rows_in;
         height_ff  <= height_in;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
            fg_ff  <= fg_in;
            bg_ff  <= bg_in;
         end
      end
   end

endmodule

// ===== hw/rtl/tcc_fifo.sv =====
// ----------------------------------------------------------------------------
// tcc_fifo
// Short job queue between the classifier and the command sequencer.
// ----------------------------------------------------------------------------
module tcc_fifo
   import tcc_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  job_type wr_job,
   output logic    q_full,
   input  logic    rd_en,
   output logic    q_empty,
   output job_type rd_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            data_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign q_full  = count_ff == CNT_W'(DEPTH);
   assign q_empty = count_ff == '0;
   assign rd_job  = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         data_ff[wr_ptr_ff] <= wr_job;
      end
   end

endmodule

// ===== hw/rtl/tcc_back.sv =====
// ----------------------------------------------------------------------------
// tcc_back
// Plays each queued job out as renderer commands, one per cycle while the
// response is popped, through a registered result stage.
// ----------------------------------------------------------------------------
module tcc_back
   import tcc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  job_type q_job,
   output logic    q_pop,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   rsp_type    out_ff, out_in;
   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       load;
   logic       is_last;
   slot_type   cur;

   assign load    = !q_empty && (!valid_ff || pop);
   assign is_last = idx_ff == (q_job.count - 2'd1);
   assign cur     = q_job.slot[idx_ff];
   assign q_pop   = load && is_last;

   always_comb begin
      out_in              = out_ff;
      valid_in            = valid_ff;
      idx_in              = idx_ff;
      if (pop && valid_ff) begin
         valid_in = 1'b0;
      end
      if (load) begin
         out_in.cmd          = cur.cmd;
         out_in.glyph_code   = cur.glyph;
         out_in.cell_row     = cur.row;
         out_in.cell_col     = cur.col;
         out_in.fg_index     = q_job.fg;
         out_in.bg_index     = q_job.bg;
         out_in.scroll_lines = cur.lines;
         out_in.last         = is_last;
         valid_in            = 1'b1;
         idx_in              = is_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign empty    = !valid_ff;
   assign rsp_data = out_ff;

endmodule

// ===== hw/rtl/text_console_cursor_controller.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_controller
// Cursor, colour and scroll control of a text console; issues draw, clear
// cell, scroll and clear screen commands to a renderer.
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  request   push / full         req_data  (op, char, cursor, lines, colour)
//  response  empty / pop         rsp_data  (one renderer command, last flag)
//  csr       csr_we              csr_index, csr_wdata (columns, rows, height)
//
//  A request is classified in the cycle it is accepted; one may be taken
//  every cycle while the job queue has room. The sequencer issues one command
//  per cycle while the response is popped, and a request causes 0 to 3 commands
//  on the response side. Synchronous reset homes the cursor, restores default
//  colours and registers and empties the queue. A stalled response backs up
//  into the queue, and full rises only once the queue is full.
// ----------------------------------------------------------------------------
module text_console_cursor_controller
   import tcc_pkg::*;
#(
   parameter int MAX_COLS     = MAX_COLS_DEF,
   parameter int MAX_ROWS     = MAX_ROWS_DEF,
   parameter int GLYPH_HEIGHT = GLYPH_HEIGHT_DEF,
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  req_type     req_data,
   output logic        empty,
   input  logic        pop,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata
);

   logic    q_full;
   logic    q_empty;
   logic    q_push;
   logic    q_pop;
   job_type q_wr_job;
   job_type q_rd_job;

   tcc_front #(
      .MAX_COLS     (MAX_COLS),
      .MAX_ROWS     (MAX_ROWS),
      .GLYPH_HEIGHT (GLYPH_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_job     (q_wr_job)
   );

   tcc_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_job  (q_wr_job),
      .q_full  (q_full),
      .rd_en   (q_pop),
      .q_empty (q_empty),
      .rd_job  (q_rd_job)
   );

   tcc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_job    (q_rd_job),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule
